@@ hdl/assert_macros.svh @@
// Assertion macros for the port-level checker of the project.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ hdl/gpm_pkg.sv @@
// Package of the glob pattern matcher: beat types, operation codes and constants.
// Used by every RTL file of the block and by its checker.
package gpm_pkg;

	localparam int MAX_PATTERN_DEF = 32;

	localparam logic [7:0] STAR_BYTE     = 8'h2A;
	localparam logic [7:0] QUESTION_BYTE = 8'h3F;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_TEXT   = 2'd2,
		OP_END    = 2'd3
	} op_t;

	typedef struct packed {
		op_t        operation;
		logic [7:0] byte_value;
	} item_t;

	typedef struct packed {
		logic matched;
		logic pattern_overflow;
	} result_t;

	// Broadcast control from the top level to every cell.
	typedef struct packed {
		logic       step;
		logic       text;
		logic       clear;
		logic [7:0] byte_value;
	} cell_ctrl_t;

	// What one cell hands to its right neighbor for the next active set.
	typedef struct packed {
		logic adv;
		logic skip;
	} link_t;

endpackage

@@ hdl/gpm_cell.sv @@
// One pattern position of the glob matcher: stored byte, occupancy and active bit.
// Depends on gpm_pkg for the control and link structs.
module gpm_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  gpm_pkg::cell_ctrl_t ctrl,
	input  logic               wr_en,
	input  logic               seed,
	input  gpm_pkg::link_t     left,
	output gpm_pkg::link_t     right,
	output logic               active
);

	logic [7:0] pat_q;
	logic       used_q;
	logic       act_q;

	logic [7:0] pat_n;
	logic       used_n;
	logic       star_cur;
	logic       star_n;
	logic       hit;
	logic       raw;

	assign active   = act_q | seed;
	assign star_cur = (pat_q == gpm_pkg::STAR_BYTE);
	assign hit    = (pat_q == gpm_pkg::QUESTION_BYTE) || (pat_q == ctrl.byte_value);

	assign pat_n  = wr_en ? ctrl.byte_value : pat_q;
	assign used_n = ctrl.clear ? 1'b0 : (used_q | wr_en);
	assign star_n = (pat_n == gpm_pkg::STAR_BYTE);

	// A star holds its own position; any other live byte moves on when it matches.
	assign raw        = left.adv | (ctrl.text & active & used_q & star_cur);
	assign right.adv  = ctrl.text & active & used_q & ~star_cur & hit;
	assign right.skip = raw & used_n & star_n;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pat_q <= ctrl.byte_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			act_q  <= 1'b0;
		end else if (ctrl.step) begin
			used_q <= used_n;
			act_q  <= raw | left.skip;
		end
	end

endmodule

@@ hdl/gpm_out_buf.sv @@
// Two-entry result buffer: output register plus skid register.
// Depends on gpm_pkg for the result beat type.
module gpm_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  gpm_pkg::result_t push_data,
	output logic             full,
	output logic             result_valid,
	input  logic             result_stall,
	output gpm_pkg::result_t result
);

	logic             out_vld_q;
	logic             skid_vld_q;
	gpm_pkg::result_t out_q;
	gpm_pkg::result_t skid_q;
	logic             pop;

	assign pop          = out_vld_q & ~result_stall;
	assign full         = skid_vld_q;
	assign result_valid = out_vld_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (out_vld_q && !pop) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_vld_q && !pop) begin
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end
	end

endmodule

@@ hdl/glob_pattern_matcher_unit.sv @@
// Top level of the glob pattern matcher: control, row of position cells, result buffer.
// Depends on gpm_pkg, gpm_cell and gpm_out_buf.
//
// Streams bytes against a stored glob pattern in which '*' matches any run of
// bytes and '?' matches exactly one byte. A beat carries an operation: clear the
// pattern, append a pattern byte, feed a text byte, or end the text. End of text
// returns one result beat with the match flag and the overflow flag; all other
// beats return nothing, and a new beat can be accepted every cycle unless the
// result buffer is full. Pattern bytes beyond MAX_PATTERN are dropped and raise
// the overflow flag until the next clear. The pattern lives in a row of
// MAX_PATTERN cells, one per position, each holding its byte and whether that
// position is active; every text byte updates all cells at once, and each cell
// only talks to its right neighbor. A '*' that directly follows another '*' is
// not stored, since it changes nothing in what the pattern matches; it still
// counts toward capacity. Results go through a two-entry buffer, so the input is
// stalled only when two results are waiting to be taken.
module glob_pattern_matcher_unit #(
	parameter int MAX_PATTERN = gpm_pkg::MAX_PATTERN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  gpm_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output gpm_pkg::result_t result
);

	localparam int PW = $clog2(MAX_PATTERN + 1);

	// Stored positions, bytes offered since the clear (saturating), flags.
	logic [PW-1:0] wr_pos_q;
	logic [PW-1:0] orig_cnt_q;
	logic          last_star_q;
	logic          ovf_q;
	logic          fresh_q;
	logic          end_q;

	logic                accept;
	logic                is_star;
	logic                room;
	logic                store;
	logic                buf_full;
	gpm_pkg::cell_ctrl_t ctrl;
	gpm_pkg::result_t    res_n;
	gpm_pkg::link_t      link [MAX_PATTERN+1];
	logic [MAX_PATTERN:0] act;

	assign item_stall = buf_full;
	assign accept     = item_valid & ~buf_full;

	assign is_star = (item.byte_value == gpm_pkg::STAR_BYTE);
	assign room    = (orig_cnt_q != PW'(MAX_PATTERN));
	assign store   = accept && (item.operation == gpm_pkg::OP_APPEND) && room &&
		!(is_star && last_star_q);

	assign ctrl.step       = accept;
	assign ctrl.text       = (item.operation == gpm_pkg::OP_TEXT);
	assign ctrl.clear      = (item.operation == gpm_pkg::OP_CLEAR);
	assign ctrl.byte_value = item.byte_value;

	// Every operation other than a text byte restarts the text at position zero.
	assign link[0].adv  = ~ctrl.text;
	assign link[0].skip = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
			gpm_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctrl   (ctrl),
				.wr_en  (store && (wr_pos_q == PW'(gi))),
				.seed   ((gi == 0) ? fresh_q : 1'b0),
				.left   (link[gi]),
				.right  (link[gi+1]),
				.active (act[gi])
			);
		end
	endgenerate

	assign act[MAX_PATTERN] = end_q;

	// The end position of the stored pattern decides the match.
	assign res_n.matched          = act[wr_pos_q];
	assign res_n.pattern_overflow = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pos_q    <= '0;
			orig_cnt_q  <= '0;
			last_star_q <= 1'b0;
			ovf_q       <= 1'b0;
			fresh_q     <= 1'b1;
			end_q       <= 1'b0;
		end else if (accept) begin
			fresh_q <= 1'b0;
			end_q   <= link[MAX_PATTERN].adv | link[MAX_PATTERN].skip;
			unique case (item.operation)
				gpm_pkg::OP_CLEAR: begin
					wr_pos_q    <= '0;
					orig_cnt_q  <= '0;
					last_star_q <= 1'b0;
					ovf_q       <= 1'b0;
				end
				gpm_pkg::OP_APPEND: begin
					if (room) begin
						orig_cnt_q <= orig_cnt_q + PW'(1);
						if (store) begin
							wr_pos_q    <= wr_pos_q + PW'(1);
							last_star_q <= is_star;
						end
					end else begin
						ovf_q <= 1'b1;
					end
				end
				gpm_pkg::OP_TEXT: begin
				end
				gpm_pkg::OP_END: begin
				end
				default: begin
				end
			endcase
		end
	end

	gpm_out_buf u_out_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (accept && (item.operation == gpm_pkg::OP_END)),
		.push_data    (res_n),
		.full         (buf_full),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

@@ hdl/gpm_checker.sv @@
// Port-level checker for the glob pattern matcher, bound to the top level.
// Depends on gpm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gpm_props (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input gpm_pkg::item_t   item,
	input logic             result_valid,
	input logic             result_stall,
	input gpm_pkg::result_t result
);

	logic acc_end;
	logic acc_clear;
	logic res_ok;

	assign acc_end   = item_valid && !item_stall && (item.operation == gpm_pkg::OP_END);
	assign acc_clear = item_valid && !item_stall && (item.operation == gpm_pkg::OP_CLEAR);
	assign res_ok    = result.matched && !result.pattern_overflow;

	// A held result beat keeps its payload.
	`ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))
	// An accepted end of text always leaves a result waiting.
	`ASSERT_NEXT(a_end_gives_result, acc_end, result_valid)
	// The input stalls only while results are waiting.
	`ASSERT_IMPL(a_stall_needs_result, item_stall, result_valid)
	// An empty pattern matches an empty text, without overflow.
	`ASSERT_NEXT(a_empty_match, acc_end && $past(acc_clear) && !result_valid, res_ok)

endmodule

bind glob_pattern_matcher_unit gpm_props u_gpm_props (.*);

@@ verif/gpm_checker.sv @@
`timescale 1ns / 1ps
// Checker for the glob pattern matcher: watches both channels, predicts results, compares them.
// Depends on gpm_pkg for beat types, operation codes and the wildcard bytes.
module gpm_checker
	import gpm_pkg::*;
#(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_stall,
	input  item_t   item,
	input  logic    result_valid,
	input  logic    result_stall,
	input  result_t result,
	output int      fail_count,
	output int      pending_count
);

	logic [7:0]           pat_mem [MAX_PATTERN];
	int                   pat_len;
	logic [MAX_PATTERN:0] live_pos;
	logic                 pat_ovf;
	result_t              verdict_q [$];

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	// An active '*' also makes the position after it active (empty run).
	function automatic void close_stars();
		for (int i = 0; i < pat_len; i++) begin
			if (live_pos[i] && pat_mem[i] == STAR_BYTE) begin
				live_pos[i+1] = 1'b1;
			end
		end
	endfunction

	function automatic void restart_text();
		live_pos    = '0;
		live_pos[0] = 1'b1;
		close_stars();
	endfunction

	function automatic void consume_text_byte(input logic [7:0] b);
		logic [MAX_PATTERN:0] nxt;
		nxt = '0;
		for (int i = 0; i < pat_len; i++) begin
			if (live_pos[i]) begin
				if (pat_mem[i] == STAR_BYTE) begin
					nxt[i] = 1'b1;
				end else if (pat_mem[i] == QUESTION_BYTE || pat_mem[i] == b) begin
					nxt[i+1] = 1'b1;
				end
			end
		end
		live_pos = nxt;
		close_stars();
	endfunction

	function automatic void apply_beat(input item_t it);
		case (it.operation)
			OP_CLEAR: begin
				pat_len = 0;
				pat_ovf = 1'b0;
				restart_text();
			end
			OP_APPEND: begin
				if (pat_len < MAX_PATTERN) begin
					pat_mem[pat_len] = it.byte_value;
					pat_len++;
				end else begin
					pat_ovf = 1'b1;
				end
				restart_text();
			end
			OP_TEXT: begin
				consume_text_byte(it.byte_value);
			end
			default: begin
				verdict_q.push_back('{matched: live_pos[pat_len], pattern_overflow: pat_ovf});
				restart_text();
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			pat_len = 0;
			pat_ovf = 1'b0;
			restart_text();
			verdict_q.delete();
			fail_count    = 0;
			pending_count = 0;
		end else begin
			// Input first: if the block ever answered in the same cycle, the
			// expectation is then already queued; otherwise order is unaffected.
			if (item_valid && !item_stall) begin
				apply_beat(item);
			end
			if (result_valid && !result_stall) begin
				if (verdict_q.size() == 0) begin
					report_mismatch("result beat with no end of text outstanding");
				end else begin
					want = verdict_q.pop_front();
					if (result.matched !== want.matched) begin
						report_mismatch($sformatf("matched is %b, expected %b",
							result.matched, want.matched));
					end
					if (result.pattern_overflow !== want.pattern_overflow) begin
						report_mismatch($sformatf("pattern_overflow is %b, expected %b",
							result.pattern_overflow, want.pattern_overflow));
					end
				end
			end
			pending_count = verdict_q.size();
		end
	end

endmodule

@@ verif/tb_glob_pattern_matcher_unit.sv @@
`timescale 1ns / 1ps
// Testbench top for the glob pattern matcher: clock, reset, stimulus and verdict.
// Depends on gpm_pkg, the block glob_pattern_matcher_unit and the checker gpm_checker.
module tb_glob_pattern_matcher_unit;
	import gpm_pkg::*;

	localparam int CAP        = MAX_PATTERN_DEF;
	localparam int ITEM_GOAL  = 550;
	localparam int MAX_GAP    = 6;
	localparam int DRAIN      = 16;
	localparam int IDLE_LIMIT = 2000;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	int fail_count;
	int pending_count;
	int beats_sent;
	int idle_cycles;

	// When set, both sides run back to back with no gaps and no stalls.
	bit calm;

	glob_pattern_matcher_unit #(
		.MAX_PATTERN (CAP)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	gpm_checker #(
		.MAX_PATTERN (CAP)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.item          (item),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Every input is known from time zero; reset is held low from the start and
	// released on a falling edge so that it never races the rising edge.
	initial begin
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '{operation: OP_CLEAR, byte_value: 8'h00};
		result_stall = 1'b0;
		calm         = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Watchdog: the run ends as a failure once the idle count, cleared whenever a
	// beat moves on either channel, reaches IDLE_LIMIT. Sender gaps and receiver
	// stalls are far shorter than that limit, so only a hung block gets here.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

	// Result side: before each result beat the receiver holds stall high for
	// a random hold of at most MAX_GAP, then takes the beat as soon as it shows up.
	initial begin
		int hold;
		wait (arst_n === 1'b1);
		forever begin
			hold = calm ? 0 : $urandom_range(0, MAX_GAP);
			repeat (hold) begin
				@(negedge clk);
				result_stall <= 1'b1;
			end
			@(negedge clk);
			result_stall <= 1'b0;
			do @(posedge clk); while (!(result_valid && !result_stall));
		end
	end

	// Drives one beat after a random gap and returns once it has been taken.
	// Valid is written once per falling edge, and the payload is held while
	// the block stalls.
	task automatic send_beat(input op_t op, input logic [7:0] b);
		int gap;
		gap = calm ? 0 : $urandom_range(0, MAX_GAP);
		repeat (gap) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item       <= '{operation: op, byte_value: b};
		do @(posedge clk); while (item_stall);
		beats_sent++;
	endtask

	// Stops sending until every outstanding end of text has been answered.
	task automatic wait_for_results();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
	endtask

	// Pattern bytes lean on the wildcards and a two-letter alphabet so that
	// texts match often; full random bytes keep every bit moving.
	function automatic logic [7:0] pick_pattern_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) return STAR_BYTE;
		if (r == 2) return QUESTION_BYTE;
		if (r < 8) return (r[0] ? 8'h61 : 8'h62);
		return 8'($urandom);
	endfunction

	// Text bytes also carry '*' and '?', which must be taken literally.
	function automatic logic [7:0] pick_text_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return (r[0] ? 8'h61 : 8'h62);
		if (r == 6) return STAR_BYTE;
		if (r == 7) return QUESTION_BYTE;
		return 8'($urandom);
	endfunction

	// One well-formed round: usually a clear, a pattern, then a few texts each
	// closed by an end of text. Most texts are built from the pattern so that
	// they tend to match; a few bytes are corrupted to land near misses.
	// Now and then a random beat of any kind is slipped in before the end.
	task automatic run_round(input bit overfill);
		int         plen;
		int         ntext;
		int         tlen;
		logic [7:0] pat [$];
		logic [7:0] b;
		if ($urandom_range(0, 7) != 0) begin
			send_beat(OP_CLEAR, 8'($urandom));
		end
		if (overfill || $urandom_range(0, 11) == 0) begin
			plen = $urandom_range(CAP - 2, CAP + 4);
		end else begin
			plen = $urandom_range(0, 7);
		end
		repeat (plen) begin
			b = pick_pattern_byte();
			pat.push_back(b);
			send_beat(OP_APPEND, b);
		end
		ntext = $urandom_range(1, 3);
		repeat (ntext) begin
			if ($urandom_range(0, 2) != 0) begin
				foreach (pat[j]) begin
					if (pat[j] == STAR_BYTE) begin
						repeat ($urandom_range(0, 3)) send_beat(OP_TEXT, pick_text_byte());
					end else if (pat[j] == QUESTION_BYTE) begin
						send_beat(OP_TEXT, 8'($urandom));
					end else if ($urandom_range(0, 15) == 0) begin
						send_beat(OP_TEXT, pick_text_byte());
					end else begin
						send_beat(OP_TEXT, pat[j]);
					end
				end
			end else begin
				tlen = $urandom_range(0, 6);
				repeat (tlen) send_beat(OP_TEXT, pick_text_byte());
			end
			if ($urandom_range(0, 9) == 0) begin
				send_beat(op_t'($urandom_range(0, 3)), 8'($urandom));
			end
			send_beat(OP_END, 8'($urandom));
		end
	endtask

	initial begin
		int rounds;
		beats_sent = 0;
		wait (arst_n === 1'b1);

		// Directed part. An empty pattern matches the empty text only.
		send_beat(OP_CLEAR, 8'h00);
		send_beat(OP_END, 8'hFF);
		send_beat(OP_TEXT, 8'hFF);
		send_beat(OP_END, 8'h00);

		// Pattern "**", 0x00, "?": a star right after a star, a zero byte
		// as a literal and a single-byte wildcard.
		send_beat(OP_APPEND, STAR_BYTE);
		send_beat(OP_APPEND, STAR_BYTE);
		send_beat(OP_APPEND, 8'h00);
		send_beat(OP_APPEND, QUESTION_BYTE);
		// Empty run for the stars, and a literal '*' in the text eaten by '?'.
		send_beat(OP_TEXT, 8'h00);
		send_beat(OP_TEXT, STAR_BYTE);
		send_beat(OP_END, 8'h00);
		// The star swallows 0xFF before the literal zero byte.
		send_beat(OP_TEXT, 8'hFF);
		send_beat(OP_TEXT, 8'h00);
		send_beat(OP_TEXT, 8'h80);
		send_beat(OP_END, 8'hFF);
		// A literal '?' in the text cannot stand in for the zero byte.
		send_beat(OP_TEXT, QUESTION_BYTE);
		send_beat(OP_END, 8'h00);
		// A text cut short by an append starts over against the longer pattern.
		send_beat(OP_TEXT, 8'h00);
		send_beat(OP_APPEND, 8'h7F);
		send_beat(OP_TEXT, 8'h00);
		send_beat(OP_TEXT, 8'h01);
		send_beat(OP_TEXT, 8'h7F);
		send_beat(OP_END, 8'h00);
		wait_for_results();

		// Random part. The first round fills the pattern store to near or past its
		// capacity so that truncation and the overflow flag are usually seen; every
		// sixth round the sender holds off until the block has answered everything.
		rounds = 0;
		while (beats_sent < ITEM_GOAL) begin
			calm = ($urandom_range(0, 4) == 0);
			run_round(rounds == 0);
			rounds++;
			if (rounds % 6 == 0) begin
				wait_for_results();
			end
		end
		calm = 1'b0;

		// Let the last results come out, then keep the clock running for a drain
		// period in case anything unexpected follows.
		wait_for_results();
		repeat (DRAIN) @(negedge clk);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
